// ===== sv/toeq_pkg.sv =====
// Shared types and codes for the time-ordered event queue.
// No dependencies; used by toeq_cell and time_ordered_event_queue.
`default_nettype none

package toeq_pkg;

  // Fixed field widths of the item payloads
  localparam int TIME_W        = 32;
  localparam int TAG_FIELD_W   = 16;
  localparam int COUNT_FIELD_W = 5;

  // Action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_INS_FULL  = 2'd2;

  typedef struct packed {
    logic                   action;
    logic [TIME_W-1:0]      event_time;
    logic [TAG_FIELD_W-1:0] event_tag;
    logic                   is_customer;
  } toeq_in_t;

  typedef struct packed {
    logic                     popped_valid;
    logic [TIME_W-1:0]        popped_time;
    logic [TAG_FIELD_W-1:0]   popped_tag;
    logic                     popped_customer;
    logic [1:0]               status;
    logic [COUNT_FIELD_W-1:0] entry_count;
    logic [TIME_W-1:0]        head_time;
    logic                     any_customer;
  } toeq_out_t;

  // Control broadcast from the top level to every cell
  typedef struct packed {
    logic upd;   // an insert or pop that changes the queue this cycle
    logic pop;   // 1: shift toward the head, 0: insert
  } toeq_ctl_t;

endpackage

`default_nettype wire

// ===== sv/toeq_cell.sv =====
// One slot of the sorted shift-register queue: holds an event and
// compares it with the incoming time. Depends on toeq_pkg.
`default_nettype none

module toeq_cell #(
  parameter int TAG_W = 16
) (
  input  wire                      clk,
  input  toeq_pkg::toeq_ctl_t      ctl,
  input  wire                      occ,        // slot index below held count
  input  wire [toeq_pkg::TIME_W-1:0] new_time,
  input  wire [TAG_W-1:0]          new_tag,
  input  wire                      new_cust,
  input  wire                      left_go,    // left neighbor keeps its event
  input  wire [toeq_pkg::TIME_W-1:0] left_time,
  input  wire [TAG_W-1:0]          left_tag,
  input  wire                      left_cust,
  input  wire [toeq_pkg::TIME_W-1:0] right_time,
  input  wire [TAG_W-1:0]          right_tag,
  input  wire                      right_cust,
  output logic                     go,         // this event sorts before the new one
  output logic [toeq_pkg::TIME_W-1:0] time_q,
  output logic [TAG_W-1:0]         tag_q,
  output logic                     cust_q
);
  import toeq_pkg::*;

  logic [TIME_W-1:0] time_r, time_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic              cust_r, cust_nxt;

  // Equal times stay ahead of the new event
  assign go = occ && (time_r <= new_time);

  // Pick keep, shift from right, take new, or shift from left
  always_comb begin
    time_nxt = time_r;
    tag_nxt  = tag_r;
    cust_nxt = cust_r;
    if (ctl.upd) begin
      if (ctl.pop) begin
        time_nxt = right_time;
        tag_nxt  = right_tag;
        cust_nxt = right_cust;
      end else if (!go) begin
        if (left_go) begin
          time_nxt = new_time;
          tag_nxt  = new_tag;
          cust_nxt = new_cust;
        end else begin
          time_nxt = left_time;
          tag_nxt  = left_tag;
          cust_nxt = left_cust;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    tag_r  <= tag_nxt;
    cust_r <= cust_nxt;
  end

  assign time_q = time_r;
  assign tag_q  = tag_r;
  assign cust_q = cust_r;

endmodule

`default_nettype wire

// ===== sv/time_ordered_event_queue.sv =====
// Time-ordered event queue: a row of sorted slots with a registered result.
// The result is registered: it is valid in the cycle after the item is accepted.
// Throughput: one item per cycle without back-pressure; every slot compares
// with the new time in parallel: insert and pop each shift the cell row once.
// Reset (rst_n low, synchronous): queue empty, no result pending.
// Depends on toeq_pkg and toeq_cell.
`default_nettype none

module time_ordered_event_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  toeq_pkg::toeq_in_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output toeq_pkg::toeq_out_t  out_data
);
  import toeq_pkg::*;

  localparam int TagW = (TAG_BITS < TAG_FIELD_W) ? TAG_BITS : TAG_FIELD_W;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0]   count_r, count_nxt;
  logic [CntW-1:0]   cust_cnt_r, cust_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  toeq_out_t         out_data_r, out_data_nxt;

  logic              accept, is_pop, empty, full, ins_ok, pop_ok;
  logic [TagW-1:0]   new_tag;
  toeq_ctl_t         ctl;

  logic [TIME_W-1:0] cell_time [QUEUE_DEPTH];
  logic [TagW-1:0]   cell_tag  [QUEUE_DEPTH];
  logic              cell_cust [QUEUE_DEPTH];
  logic              cell_go   [QUEUE_DEPTH];

  // Handshake: output register frees when its item is taken
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_pop    = (in_data.action == ACT_POP);
  assign empty     = (count_r == '0);
  assign full      = (count_r == CntW'(QUEUE_DEPTH));
  assign ins_ok    = accept && !is_pop && !full;
  assign pop_ok    = accept && is_pop && !empty;
  assign new_tag   = in_data.event_tag[TagW-1:0];
  assign ctl.upd   = ins_ok || pop_ok;
  assign ctl.pop   = is_pop;

  // Row of cells; head at index 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic              l_go;
    logic [TIME_W-1:0] l_time, r_time;
    logic [TagW-1:0]   l_tag, r_tag;
    logic              l_cust, r_cust;

    if (i == 0) begin : g_head
      assign l_go   = 1'b1;
      assign l_time = in_data.event_time;
      assign l_tag  = new_tag;
      assign l_cust = in_data.is_customer;
    end else begin : g_mid
      assign l_go   = cell_go[i-1];
      assign l_time = cell_time[i-1];
      assign l_tag  = cell_tag[i-1];
      assign l_cust = cell_cust[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_time = cell_time[i];
      assign r_tag  = cell_tag[i];
      assign r_cust = cell_cust[i];
    end else begin : g_body
      assign r_time = cell_time[i+1];
      assign r_tag  = cell_tag[i+1];
      assign r_cust = cell_cust[i+1];
    end

    toeq_cell #(.TAG_W(TagW)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (CntW'(i) < count_r),
      .new_time   (in_data.event_time),
      .new_tag    (new_tag),
      .new_cust   (in_data.is_customer),
      .left_go    (l_go),
      .left_time  (l_time),
      .left_tag   (l_tag),
      .left_cust  (l_cust),
      .right_time (r_time),
      .right_tag  (r_tag),
      .right_cust (r_cust),
      .go         (cell_go[i]),
      .time_q     (cell_time[i]),
      .tag_q      (cell_tag[i]),
      .cust_q     (cell_cust[i])
    );
  end

  // Count and customer count bookkeeping
  always_comb begin
    count_nxt    = count_r;
    cust_cnt_nxt = cust_cnt_r;
    if (ins_ok) begin
      count_nxt = count_r + CntW'(1);
      if (in_data.is_customer) cust_cnt_nxt = cust_cnt_r + CntW'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - CntW'(1);
      if (cell_cust[0]) cust_cnt_nxt = cust_cnt_r - CntW'(1);
    end
  end

  // Result item built from the state after this item
  always_comb begin
    out_data_nxt                 = '0;
    out_data_nxt.entry_count     = COUNT_FIELD_W'(count_nxt);
    out_data_nxt.any_customer    = (cust_cnt_nxt != '0);
    if (ins_ok) begin
      out_data_nxt.head_time = cell_go[0] ? cell_time[0] : in_data.event_time;
    end else if (pop_ok) begin
      out_data_nxt.popped_valid    = 1'b1;
      out_data_nxt.popped_time     = cell_time[0];
      out_data_nxt.popped_tag      = TAG_FIELD_W'(cell_tag[0]);
      out_data_nxt.popped_customer = cell_cust[0];
      out_data_nxt.head_time       = (count_r > CntW'(1)) ? cell_time[1] : '0;
    end else begin
      out_data_nxt.status    = is_pop ? STATUS_POP_EMPTY : STATUS_INS_FULL;
      out_data_nxt.head_time = empty ? '0 : cell_time[0];
    end
  end

  assign out_valid_nxt = accept || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cust_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cust_cnt_r  <= cust_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded on accept
  always_ff @(posedge clk) begin
    if (accept) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== tb/time_ordered_event_queue_tb.sv =====
// Self-checking testbench for time_ordered_event_queue: insert/pop items with random idling.
// Results are checked field by field against an in-bench sorted-queue predictor.
// Depends on toeq_pkg and the time_ordered_event_queue RTL.
`timescale 1ns / 1ps

module time_ordered_event_queue_tb;
  import toeq_pkg::*;

  localparam int TB_DEPTH    = 16;
  localparam int TB_TAG_BITS = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 800;
  localparam logic [TAG_FIELD_W-1:0] TAG_KEEP =
    TAG_FIELD_W'((64'd1 << TB_TAG_BITS) - 64'd1);

  // Time distributions for generated events
  typedef enum int {TM_NARROW, TM_SHORT, TM_FULL, TM_EXTREME} time_mode_e;
  // Random phase shapes
  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  toeq_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  toeq_out_t out_data;

  time_ordered_event_queue #(
    .QUEUE_DEPTH(TB_DEPTH),
    .TAG_BITS   (TB_TAG_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Stimulus and expectation stores
  toeq_in_t  event_cmds[$];
  toeq_out_t predicted_results[$];

  // Predictor state: sorted slots, earliest at index 0
  logic [TIME_W-1:0]      slot_t [TB_DEPTH];
  logic [TAG_FIELD_W-1:0] slot_g [TB_DEPTH];
  logic                   slot_c [TB_DEPTH];
  int                     held_events = 0;

  // Run statistics
  int mismatches    = 0;
  int n_inserts     = 0;
  int n_pops        = 0;
  int full_rejects  = 0;
  int empty_rejects = 0;
  int peak_held     = 0;
  int n_results     = 0;

  // Handshake bookkeeping
  logic in_took   = 1'b0;
  logic out_took  = 1'b0;
  logic in_idle_en  = 1'b0;
  logic out_idle_en = 1'b0;
  int   quiet_cycles = 0;
  int   gen_count    = 0;

  // Apply one item to the predictor and return the result it should produce
  function automatic toeq_out_t sorted_queue_step(toeq_in_t it);
    toeq_out_t r;
    int pos;
    int k;
    r = '0;
    if (it.action == ACT_INSERT) begin
      n_inserts++;
      if (held_events >= TB_DEPTH) begin
        r.status = STATUS_INS_FULL;
        full_rejects++;
      end else begin
        // equal times: new event lands after the queued ones
        pos = 0;
        while (pos < held_events && slot_t[pos] <= it.event_time) pos++;
        for (k = held_events; k > pos; k--) begin
          slot_t[k] = slot_t[k-1];
          slot_g[k] = slot_g[k-1];
          slot_c[k] = slot_c[k-1];
        end
        slot_t[pos] = it.event_time;
        slot_g[pos] = it.event_tag & TAG_KEEP;
        slot_c[pos] = it.is_customer;
        held_events++;
      end
    end else begin
      n_pops++;
      if (held_events == 0) begin
        r.status = STATUS_POP_EMPTY;
        empty_rejects++;
      end else begin
        r.popped_valid    = 1'b1;
        r.popped_time     = slot_t[0];
        r.popped_tag      = slot_g[0];
        r.popped_customer = slot_c[0];
        for (k = 1; k < held_events; k++) begin
          slot_t[k-1] = slot_t[k];
          slot_g[k-1] = slot_g[k];
          slot_c[k-1] = slot_c[k];
        end
        held_events--;
      end
    end
    if (held_events > peak_held) peak_held = held_events;
    r.entry_count = COUNT_FIELD_W'(held_events);
    r.head_time   = (held_events != 0) ? slot_t[0] : '0;
    for (k = 0; k < held_events; k++)
      if (slot_c[k]) r.any_customer = 1'b1;
    return r;
  endfunction

  // One line per mismatch, and a running count
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
             $realtime, n_results, what, got, want);
  endtask

  task automatic check_result(toeq_out_t got);
    toeq_out_t want;
    if (predicted_results.size() == 0) begin
      report_mismatch("unexpected result", 32'(got.entry_count), 32'd0);
    end else begin
      want = predicted_results.pop_front();
      if (got.popped_valid !== want.popped_valid)
        report_mismatch("popped_valid", 32'(got.popped_valid), 32'(want.popped_valid));
      if (got.popped_time !== want.popped_time)
        report_mismatch("popped_time", got.popped_time, want.popped_time);
      if (got.popped_tag !== want.popped_tag)
        report_mismatch("popped_tag", 32'(got.popped_tag), 32'(want.popped_tag));
      if (got.popped_customer !== want.popped_customer)
        report_mismatch("popped_customer", 32'(got.popped_customer),
                        32'(want.popped_customer));
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.entry_count !== want.entry_count)
        report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
      if (got.head_time !== want.head_time)
        report_mismatch("head_time", got.head_time, want.head_time);
      if (got.any_customer !== want.any_customer)
        report_mismatch("any_customer", 32'(got.any_customer), 32'(want.any_customer));
    end
    n_results++;
  endtask

  // Sample both handshakes, predict, check, and watch for a hang
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took      <= 1'b0;
      out_took     <= 1'b0;
      quiet_cycles = 0;
    end else begin
      in_took  <= in_valid && in_ready;
      out_took <= out_valid && out_ready;
      if (in_valid && in_ready)
        predicted_results.push_back(sorted_queue_step(in_data));
      if (out_valid && out_ready)
        check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else if (in_valid || event_cmds.size() != 0 || predicted_results.size() != 0)
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] no progress for %0d cycles, %0d results outstanding",
                 $realtime, quiet_cycles, predicted_results.size());
        $display("time_ordered_event_queue_tb: FAIL");
        $finish;
      end
    end
  end

  // Input driver: presents the next command, then idles for its drawn gap
  int send_wait = 0;
  always @(negedge clk) begin
    logic next_v;
    next_v = in_valid;
    if (rst_n) begin
      if (in_valid && !in_took) begin
        next_v = 1'b1;
      end else if (send_wait > 0) begin
        send_wait--;
        next_v = 1'b0;
      end else if (event_cmds.size() != 0) begin
        in_data   <= event_cmds.pop_front();
        next_v    = 1'b1;
        send_wait = in_idle_en ? $urandom_range(0, 9) : 0;
      end else begin
        next_v = 1'b0;
      end
      in_valid <= next_v;
    end
  end

  // Result receiver: stalls for a drawn gap after each item
  int recv_wait = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) recv_wait = out_idle_en ? $urandom_range(0, 9) : 0;
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Queue one command and track the occupancy it will leave behind
  task automatic add_cmd(logic act, logic [TIME_W-1:0] t, logic [TAG_FIELD_W-1:0] tag,
                         logic cust);
    toeq_in_t c;
    c.action      = act;
    c.event_time  = t;
    c.event_tag   = tag;
    c.is_customer = cust;
    event_cmds.push_back(c);
    if (act == ACT_INSERT && gen_count < TB_DEPTH) gen_count++;
    else if (act == ACT_POP && gen_count > 0) gen_count--;
  endtask

  function automatic logic [TIME_W-1:0] pick_time(time_mode_e m);
    case (m)
      TM_NARROW: return TIME_W'($urandom_range(0, 7));
      TM_SHORT:  return TIME_W'($urandom_range(0, 255));
      TM_FULL:   return TIME_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return {{(TIME_W-1){1'b1}}, 1'b0};
          default: return TIME_W'($urandom);
        endcase
      end
    endcase
  endfunction

  // Hold the sender until every expected result is back
  task automatic wait_drained();
    while (event_cmds.size() != 0 || in_valid || predicted_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int i;
    int len;
    int sent;
    int pop_pct;
    phase_e ph;
    time_mode_e tm;

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: empty pop, empty insert, extremes, equal-time ordering
    add_cmd(ACT_POP,    '0, '0, 1'b0);
    add_cmd(ACT_INSERT, '0, '0, 1'b0);
    add_cmd(ACT_INSERT, '1, '1, 1'b1);
    add_cmd(ACT_INSERT, '0, 16'h0001, 1'b0);
    add_cmd(ACT_POP,    '1, '1, 1'b1);
    add_cmd(ACT_POP,    '0, '0, 1'b0);
    add_cmd(ACT_POP,    '0, '0, 1'b0);  // last customer leaves
    add_cmd(ACT_POP,    '1, '1, 1'b1);  // pop on an empty queue again
    // Fill to capacity with descending times in equal pairs, then overflow
    for (i = 0; i < TB_DEPTH; i++)
      add_cmd(ACT_INSERT, TIME_W'(100 - (i / 2) * 3), TAG_FIELD_W'(i * 4099), i[0]);
    add_cmd(ACT_INSERT, '0, 16'hA5A5, 1'b1);
    wait_drained();

    // Random phases: fill bursts, drain bursts and mixed traffic
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      ph  = phase_e'($urandom_range(0, 2));
      tm  = time_mode_e'($urandom_range(0, 3));
      len = $urandom_range(20, 60);
      in_idle_en  = ($urandom_range(0, 3) != 0);
      out_idle_en = ($urandom_range(0, 3) != 0);
      case (ph)
        PH_FILL:  pop_pct = 15;
        PH_DRAIN: pop_pct = 85;
        default:  pop_pct = 50;
      endcase
      repeat (len) begin
        // a few overflow and underflow attempts, but mostly useful traffic
        if (gen_count == TB_DEPTH && $urandom_range(0, 99) < 60)
          add_cmd(ACT_POP, TIME_W'($urandom), TAG_FIELD_W'($urandom), 1'($urandom));
        else if (gen_count == 0 && $urandom_range(0, 99) < 60)
          add_cmd(ACT_INSERT, pick_time(tm), TAG_FIELD_W'($urandom),
                  1'($urandom_range(0, 3) == 0));
        else if ($urandom_range(0, 99) < pop_pct)
          add_cmd(ACT_POP, TIME_W'($urandom), TAG_FIELD_W'($urandom), 1'($urandom));
        else
          add_cmd(ACT_INSERT, pick_time(tm), TAG_FIELD_W'($urandom),
                  1'($urandom_range(0, 3) == 0));
      end
      sent += len;
      if ($urandom_range(0, 3) == 0)
        wait_drained();
      else
        while (event_cmds.size() != 0) @(posedge clk);
    end

    wait_drained();
    repeat (10) @(posedge clk);

    $display("covered %0d inserts and %0d pops, %0d results checked, peak occupancy %0d",
             n_inserts, n_pops, n_results, peak_held);
    $display("rejected %0d inserts on a full queue and %0d pops on an empty one",
             full_rejects, empty_rejects);
    if (mismatches == 0)
      $display("time_ordered_event_queue_tb: PASS");
    else
      $display("time_ordered_event_queue_tb: FAIL");
    $finish;
  end

endmodule
